/* rtl/lzw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lzw_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EMIT_PFX,
    ST_EMIT_TAIL,
    ST_EMIT_END
  } lzw_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_item;   // capture byte, flag and begin the dictionary scan
    logic scan_step;    // advance the scan pointer by one entry
    logic take_hit;     // prefix becomes the matching code
    logic add_miss;     // write the new pair and restart the prefix at the byte
    logic first_item;   // prefix restarts at the byte without a search
    logic end_reset;    // return to the empty dictionary
  } lzw_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic started;
    logic scan_done;    // the entry under the pointer is past the last valid code
    logic scan_hit;     // the entry read last matches the key
    logic last_flag;
  } lzw_stat_t;

  typedef enum logic [1:0] {
    SEL_CLEAR,
    SEL_PREFIX,
    SEL_END
  } lzw_osel_e;

endpackage
`default_nettype wire

/* rtl/lzw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lzw_datapath #(
  parameter int DictCodes = 512,
  parameter int CodeWidth = 9
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [7:0]          data_byte_i,
  input  wire logic                end_of_stream_i,
  input  wire lzw_pkg::lzw_cmd_t   cmd_i,
  output lzw_pkg::lzw_stat_t       stat_o,
  output logic [CodeWidth-1:0]     prefix_o
);
  import lzw_pkg::*;

  localparam int Entries = DictCodes - 258;
  localparam int AddrW   = $clog2(Entries);
  localparam int FreeW   = CodeWidth + 1;
  localparam int EntryW  = CodeWidth + 8;

  logic [EntryW-1:0]    mem_q [Entries];
  logic [EntryW-1:0]    rd_q;
  logic [FreeW-1:0]     free_q, free_d;
  logic [FreeW-1:0]     ptr_q, ptr_d;
  logic [FreeW-1:0]     hit_code_q;
  logic                 rd_vld_q;
  logic [CodeWidth-1:0] prefix_q, prefix_d;
  logic [7:0]           byte_q;
  logic                 last_q;
  logic                 started_q, started_d;
  logic [EntryW-1:0]    key;
  logic [FreeW-1:0]     first_free;
  logic [FreeW-1:0]     rd_idx;

  assign first_free = FreeW'(258);
  assign key        = {prefix_q, byte_q};
  assign rd_idx     = ptr_q - first_free;

  // Memory: one write port for new pairs, one registered read port for the scan.
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_miss && (free_q < FreeW'(DictCodes))) begin
      mem_q[AddrW'(free_q - first_free)] <= key;
    end
    rd_q <= mem_q[AddrW'(rd_idx)];
  end

  always_comb begin
    free_d    = free_q;
    prefix_d  = prefix_q;
    started_d = started_q;
    ptr_d     = ptr_q;
    if (cmd_i.start_item) begin
      ptr_d = first_free;
    end else if (cmd_i.scan_step) begin
      ptr_d = ptr_q + FreeW'(1);
    end
    if (cmd_i.first_item) begin
      prefix_d  = CodeWidth'(byte_q);
      started_d = 1'b1;
    end
    if (cmd_i.take_hit) begin
      prefix_d = hit_code_q[CodeWidth-1:0];
    end
    if (cmd_i.add_miss) begin
      prefix_d = CodeWidth'(byte_q);
      if (free_q < FreeW'(DictCodes)) begin
        free_d = free_q + FreeW'(1);
      end
    end
    if (cmd_i.end_reset) begin
      free_d    = first_free;
      prefix_d  = '0;
      started_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q    <= FreeW'(258);
      prefix_q  <= '0;
      started_q <= 1'b0;
      ptr_q     <= FreeW'(258);
      rd_vld_q  <= 1'b0;
    end else begin
      free_q    <= free_d;
      prefix_q  <= prefix_d;
      started_q <= started_d;
      ptr_q     <= ptr_d;
      rd_vld_q  <= cmd_i.scan_step && (ptr_q < free_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_item) begin
      byte_q <= data_byte_i;
      last_q <= end_of_stream_i;
    end
    hit_code_q <= ptr_q;
  end

  // The read data is registered and lags the pointer, so a hit belongs to ptr_q - 1.
  always_comb begin
    stat_o.started   = started_q;
    stat_o.scan_hit  = rd_vld_q && (rd_q == key);
    stat_o.scan_done = (ptr_q >= free_q) && !rd_vld_q;
    stat_o.last_flag = last_q;
  end

  assign prefix_o = prefix_q;
endmodule
`default_nettype wire

/* rtl/lzw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module lzw_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output lzw_pkg::lzw_osel_e       osel_o,
  output lzw_pkg::lzw_cmd_t        cmd_o,
  input  wire lzw_pkg::lzw_stat_t  stat_i
);
  import lzw_pkg::*;

  lzw_state_e state_q, state_d;
  logic       fire;

  assign fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    osel_o      = SEL_PREFIX;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start_item = 1'b1;
          state_d          = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!stat_i.started) begin
          // First byte of a stream: the clear code goes out first.
          out_valid_o = 1'b1;
          osel_o      = SEL_CLEAR;
          if (fire) begin
            cmd_o.first_item = 1'b1;
            state_d = stat_i.last_flag ? ST_EMIT_TAIL : ST_IDLE;
          end
        end else if (stat_i.scan_hit) begin
          cmd_o.take_hit = 1'b1;
          state_d = stat_i.last_flag ? ST_EMIT_TAIL : ST_IDLE;
        end else if (stat_i.scan_done) begin
          state_d = ST_EMIT_PFX;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      ST_EMIT_PFX: begin
        out_valid_o = 1'b1;
        if (fire) begin
          cmd_o.add_miss = 1'b1;
          state_d = stat_i.last_flag ? ST_EMIT_TAIL : ST_IDLE;
        end
      end
      ST_EMIT_TAIL: begin
        out_valid_o = 1'b1;
        if (fire) begin
          state_d = ST_EMIT_END;
        end
      end
      ST_EMIT_END: begin
        out_valid_o = 1'b1;
        osel_o      = SEL_END;
        if (fire) begin
          cmd_o.end_reset = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/lzw_compressor_9bit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Signals                                   Direction
// in       in_valid_i in_ready_o data_byte_i end_of_stream_i    request in
// out      out_valid_o out_ready_i code_word_o last_of_stream_o  request out
// A request scans the dictionary one entry per cycle through a registered
// memory read port. Results wait while out_ready_i is low, and no new
// request is taken until all codes of the current one are delivered.
// Reset empties the dictionary and starts a new stream.
module lzw_compressor_9bit #(
  parameter int DictCodes = 512,
  parameter int CodeWidth = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           data_byte_i,
  input  wire logic                 end_of_stream_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [CodeWidth-1:0]      code_word_o,
  output logic                      last_of_stream_o
);
  import lzw_pkg::*;

  lzw_cmd_t             cmd;
  lzw_stat_t            stat;
  lzw_osel_e            osel;
  logic [CodeWidth-1:0] prefix;

  lzw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .osel_o      (osel),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  lzw_datapath #(
    .DictCodes (DictCodes),
    .CodeWidth (CodeWidth)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .prefix_o        (prefix)
  );

  always_comb begin
    unique case (osel)
      SEL_CLEAR:  code_word_o = CodeWidth'(256);
      SEL_END:    code_word_o = CodeWidth'(257);
      default:    code_word_o = prefix;
    endcase
    last_of_stream_o = (osel == SEL_END);
  end
endmodule
`default_nettype wire

/* dv/lzw_compressor_9bit_test.sv */
`timescale 1ns / 1ps
module lzw_compressor_9bit_test;

  localparam int DictCodes = 512;
  localparam int CodeWidth = 9;
  localparam logic [CodeWidth-1:0] ClearCode = 9'd256;
  localparam logic [CodeWidth-1:0] EndCode = 9'd257;
  localparam int FirstFree = 258;
  localparam int WatchdogLimit = 20000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } byte_req_t;

  typedef struct packed {
    logic [CodeWidth-1:0] code_word;
    logic                 last_of_stream;
  } code_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [7:0] data_byte_i = '0;
  logic end_of_stream_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [CodeWidth-1:0] code_word_o;
  logic last_of_stream_o;

  lzw_compressor_9bit DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .end_of_stream_i,
    .out_valid_o, .out_ready_i, .code_word_o, .last_of_stream_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Predictor state: the dictionary of (prefix, byte) pairs.
  logic [CodeWidth+7:0] pair_dict [FirstFree:DictCodes-1];
  int dict_fill = FirstFree;
  logic [CodeWidth-1:0] cur_prefix = '0;
  bit stream_open = 1'b0;

  byte_req_t pending_bytes[$];
  code_res_t expected_codes[$];
  int errors = 0;
  int bytes_sent = 0;
  int codes_seen = 0;
  int streams_done = 0;
  bit quiet_tail = 1'b0;
  bit hold_sender = 1'b0;
  int long_stall = 0;

  function automatic void push_code(logic [CodeWidth-1:0] c, logic l);
    code_res_t r;
    r.code_word = c;
    r.last_of_stream = l;
    expected_codes.push_back(r);
  endfunction

  function automatic void compress_byte(byte_req_t b);
    int hit;
    hit = 0;
    if (!stream_open) begin
      push_code(ClearCode, 1'b0);
      stream_open = 1'b1;
      cur_prefix = {1'b0, b.data_byte};
    end else begin
      for (int c = FirstFree; c < dict_fill; c++) begin
        if (hit == 0 && pair_dict[c] == {cur_prefix, b.data_byte}) hit = c;
      end
      if (hit != 0) begin
        cur_prefix = hit[CodeWidth-1:0];
      end else begin
        if (dict_fill < DictCodes) begin
          pair_dict[dict_fill] = {cur_prefix, b.data_byte};
          dict_fill++;
        end
        push_code(cur_prefix, 1'b0);
        cur_prefix = {1'b0, b.data_byte};
      end
    end
    if (b.end_of_stream) begin
      push_code(cur_prefix, 1'b0);
      push_code(EndCode, 1'b1);
      dict_fill = FirstFree;
      cur_prefix = '0;
      stream_open = 1'b0;
    end
  endfunction

  function automatic void add_byte(logic [7:0] d, logic e);
    byte_req_t b;
    b.data_byte = d;
    b.end_of_stream = e;
    pending_bytes.push_back(b);
  endfunction

  // Driver with random idle bursts.
  int send_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        compress_byte({data_byte_i, end_of_stream_i});
        bytes_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_bytes.size() > 0 && !hold_sender) begin
          byte_req_t b;
          b = pending_bytes.pop_front();
          in_valid_i <= 1'b1;
          data_byte_i <= b.data_byte;
          end_of_stream_i <= b.end_of_stream;
          if (!quiet_tail && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stalls.
  int recv_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        codes_seen++;
        if (expected_codes.size() == 0) begin
          $error("unexpected code_word %0d", code_word_o);
          errors++;
        end else begin
          code_res_t r;
          r = expected_codes.pop_front();
          if (r.code_word !== code_word_o) begin
            $error("code_word expected %0d actual %0d", r.code_word, code_word_o);
            errors++;
          end
          if (r.last_of_stream !== last_of_stream_o) begin
            $error("last_of_stream expected %0b actual %0b", r.last_of_stream,
                   last_of_stream_o);
            errors++;
          end
          if (r.last_of_stream) streams_done++;
        end
      end
      if (long_stall > 0) begin
        long_stall <= long_stall - 1;
        out_ready_i <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 6) == 0) begin
        recv_gap <= $urandom_range(0, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int len;
    // Directed: single-byte stream, extremes, repeats that hit the dictionary.
    add_byte(8'h00, 1'b1);
    add_byte(8'hFF, 1'b1);
    for (int i = 0; i < 8; i++) add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    for (int i = 0; i < 6; i++) add_byte(8'hFF, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b0);
    add_byte(8'hAA, 1'b0);
    add_byte(8'h55, 1'b1);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_bytes.size() == 0 && expected_codes.size() == 0 && !in_valid_i);
    // Hold the receiver while the sender keeps offering bytes.
    for (int i = 0; i < 12; i++) add_byte(8'($urandom_range(0, 3)), 1'b0);
    add_byte(8'($urandom), 1'b1);
    @(posedge clk_i);
    long_stall <= 400;
    wait (pending_bytes.size() == 0 && expected_codes.size() == 0 && !in_valid_i);
    // Random streams over small alphabets so matches are common.
    while (bytes_sent < 210) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 3) == 0) add_byte(8'($urandom), i == len - 1);
        else add_byte(8'($urandom_range(0, 3)), i == len - 1);
      end
      if ($urandom_range(0, 4) == 0) begin
        // Sender pauses until all results are back.
        wait (pending_bytes.size() == 0 && !in_valid_i);
        hold_sender = 1'b1;
        wait (expected_codes.size() == 0);
        hold_sender = 1'b0;
      end
      wait (pending_bytes.size() == 0);
      if (bytes_sent > 170) quiet_tail = 1'b1;
    end
    wait (pending_bytes.size() == 0 && !in_valid_i);
    wait (expected_codes.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Sent %0d bytes in %0d streams, checked %0d codes,", bytes_sent,
             streams_done, codes_seen);
    $display("including a long output stall and dictionary hits and misses.");
    if (errors == 0 && expected_codes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
